// ===== rtl/vmes_pkg.sv =====
// Shared widths, mode codes and sideband type for the von Mises stress pipeline.
package vmes_pkg;

  localparam int Q_W    = 32;
  localparam int MAG_W  = Q_W + 1;
  localparam int SQ_W   = 2 * Q_W + 1;
  localparam int SUM_W  = SQ_W + 2;
  localparam int TOT_W  = SUM_W + 1;
  localparam int RAD_W  = 2 * Q_W - 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int LANES  = 6;

  localparam logic [1:0] DIM_1D = 2'd0;
  localparam logic [1:0] DIM_2D = 2'd1;
  localparam logic [1:0] DIM_3D = 2'd2;

  localparam logic [Q_W-1:0] MAX_Q = {1'b0, {(Q_W-1){1'b1}}};

  typedef struct packed {
    logic           bypass;
    logic           sat;
    logic [Q_W-1:0] value;
  } vmes_side_t;

  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [MAG_W-1:0] v);
    logic [MAG_W-1:0] r;
    r = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    return r;
  endfunction

endpackage

// ===== rtl/von_mises_equivalent_stress.sv =====
// Top level: von Mises equivalent stress of one Voigt stress state per transaction.
// Pipeline: 4 arithmetic stages followed by 31 root stages.
// Throughput: one transaction per cycle while the output is not stalled; the root takes one bit per stage.
// The whole pipeline holds while a result waits on m_axis_tready_i.
// Reset clears all valid bits and sets the dimension mode to three-dimensional.
module von_mises_equivalent_stress
  import vmes_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // normal_x, normal_y, normal_z, shear_yz, shear_zx, shear_xy (32 bits each)
  input  logic [191:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // equivalent_stress
  output logic [31:0]  m_axis_tdata_o,
  // saturated
  output logic         m_axis_tuser_o
);

  logic       en;
  logic [1:0] dim_mode_q;
  logic       is2d;

  logic signed [Q_W-1:0]   in_f [LANES];
  logic signed [MAG_W-1:0] ext  [LANES];
  logic [MAG_W-1:0]        mag_d [LANES];

  logic                 s1_valid_q;
  logic                 s1_bypass_q;
  logic [Q_W-1:0]       s1_x_q;
  logic [MAG_W-1:0]     s1_mag_q [LANES];

  logic                 s2_valid_q;
  logic                 s2_bypass_q;
  logic [Q_W-1:0]       s2_x_q;
  logic [SQ_W-1:0]      s2_sq_q [LANES];
  logic [2*MAG_W-1:0]   prod [LANES];

  logic                 s3_valid_q;
  logic                 s3_bypass_q;
  logic [Q_W-1:0]       s3_x_q;
  logic [SUM_W-1:0]     s3_norm_q;
  logic [SUM_W-1:0]     s3_shear_q;

  logic                 s4_valid_q;
  logic [RAD_W-1:0]     s4_rad_q;
  vmes_side_t           s4_side_q;
  logic [TOT_W-1:0]     total_d;
  logic                 over_d;
  vmes_side_t           side_d;

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign is2d            = dim_mode_q == DIM_2D;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_mode_q <= DIM_3D;
    end else if (cfg_we_i) begin
      dim_mode_q <= cfg_wdata_i;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_unpack
    assign in_f[i] = s_axis_tdata_i[i*Q_W +: Q_W];
    assign ext[i]  = MAG_W'(in_f[i]);
  end

  always_comb begin
    mag_d[0] = abs_mag(ext[0] - ext[1]);
    mag_d[1] = is2d ? abs_mag(ext[0]) : abs_mag(ext[1] - ext[2]);
    mag_d[2] = is2d ? abs_mag(ext[1]) : abs_mag(ext[2] - ext[0]);
    mag_d[3] = is2d ? '0 : abs_mag(ext[3]);
    mag_d[4] = is2d ? '0 : abs_mag(ext[4]);
    mag_d[5] = abs_mag(ext[5]);
  end

  for (genvar i = 0; i < LANES; i++) begin : g_square
    assign prod[i] = (2*MAG_W)'(s1_mag_q[i]) * (2*MAG_W)'(s1_mag_q[i]);
  end

  assign total_d = TOT_W'(s3_norm_q >> 1) + TOT_W'(s3_shear_q) + (TOT_W'(s3_shear_q) << 1);
  assign over_d  = |total_d[TOT_W-1:RAD_W];

  always_comb begin
    side_d.bypass = s3_bypass_q;
    side_d.sat    = !s3_bypass_q && over_d;
    side_d.value  = s3_bypass_q ? s3_x_q : MAX_Q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_bypass_q <= dim_mode_q == DIM_1D;
      s1_x_q      <= in_f[0];
      s1_mag_q    <= mag_d;
      s2_bypass_q <= s1_bypass_q;
      s2_x_q      <= s1_x_q;
      for (int i = 0; i < LANES; i++) begin
        s2_sq_q[i] <= SQ_W'(prod[i]);
      end
      s3_bypass_q <= s2_bypass_q;
      s3_x_q      <= s2_x_q;
      s3_norm_q   <= SUM_W'(s2_sq_q[0]) + SUM_W'(s2_sq_q[1]) + SUM_W'(s2_sq_q[2]);
      s3_shear_q  <= SUM_W'(s2_sq_q[3]) + SUM_W'(s2_sq_q[4]) + SUM_W'(s2_sq_q[5]);
      s4_rad_q    <= total_d[RAD_W-1:0];
      s4_side_q   <= side_d;
    end
  end

  vmes_isqrt u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s4_valid_q),
    .rad_i    (s4_rad_q),
    .side_i   (s4_side_q),
    .valid_o  (m_axis_tvalid_o),
    .result_o (m_axis_tdata_o),
    .sat_o    (m_axis_tuser_o)
  );

  a_sat_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == MAX_Q)
    else $error("saturated result not clamped");

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a blocked result");

  a_normal_sum_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> !s3_norm_q[0])
    else $error("normal difference sum is odd");

  a_bypass_not_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q && s4_side_q.bypass |-> !s4_side_q.sat)
    else $error("one-dimensional transaction flagged saturated");

endmodule

// ===== rtl/vmes_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, with sideband and final select.
module vmes_isqrt
  import vmes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RAD_W-1:0] rad_i,
  input  vmes_side_t       side_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   result_o,
  output logic             sat_o
);

  logic              vld_in  [ROOT_W];
  logic [RAD_W-1:0]  rem_in  [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  vmes_side_t        side_in [ROOT_W];
  logic [RAD_W-1:0]  rem_d   [ROOT_W];
  logic [ROOT_W-1:0] root_d  [ROOT_W];

  logic              vld_q  [ROOT_W-1];
  logic [RAD_W-1:0]  rem_q  [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W-1];
  vmes_side_t        side_q [ROOT_W-1];

  logic              out_valid_q;
  logic [Q_W-1:0]    out_value_q;
  logic              out_sat_q;

  assign vld_in[0]  = valid_i;
  assign rem_in[0]  = rad_i;
  assign root_in[0] = '0;
  assign side_in[0] = side_i;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    localparam int K = ROOT_W - 1 - j;
    logic [RAD_W:0] trial;
    logic           ge;

    if (j > 0) begin : g_link
      assign vld_in[j]  = vld_q[j-1];
      assign rem_in[j]  = rem_q[j-1];
      assign root_in[j] = root_q[j-1];
      assign side_in[j] = side_q[j-1];
    end

    assign trial = ((RAD_W+1)'(root_in[j]) << (K + 1)) | ((RAD_W+1)'(1) << (2 * K));
    assign ge    = {1'b0, rem_in[j]} >= trial;
    assign rem_d[j]  = ge ? RAD_W'({1'b0, rem_in[j]} - trial) : rem_in[j];
    assign root_d[j] = root_in[j] | (ROOT_W'(ge) << K);

    if (j < ROOT_W - 1) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[j] <= 1'b0;
        end else if (en_i) begin
          vld_q[j] <= vld_in[j];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j]  <= rem_d[j];
          root_q[j] <= root_d[j];
          side_q[j] <= side_in[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= vld_in[ROOT_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_value_q <= (side_in[ROOT_W-1].bypass || side_in[ROOT_W-1].sat) ?
                     side_in[ROOT_W-1].value : Q_W'(root_d[ROOT_W-1]);
      out_sat_q   <= side_in[ROOT_W-1].sat;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = out_value_q;
  assign sat_o    = out_sat_q;

endmodule
